@@ src/smx_pkg.sv @@
package smx_pkg;

  // Stack: the top entry sits in a register, the entries below it in memory.
  // All store depths are powers of two, given by their address widths.
  localparam int STACK_AW    = 8;
  localparam int STACK_DEPTH = 1 << STACK_AW;
  localparam int CNT_W       = STACK_AW + 1;
  localparam int LOCALS_AW   = 8;
  localparam int POOL_AW     = 8;

  localparam logic [31:0] SIGN_BYTE = 32'h0000_0080;
  localparam logic [31:0] EXT_BYTE  = 32'hFFFF_FF00;

  localparam logic [4:0] FN_ADD     = 5'd0;
  localparam logic [4:0] FN_SUB     = 5'd1;
  localparam logic [4:0] FN_AND     = 5'd2;
  localparam logic [4:0] FN_OR      = 5'd3;
  localparam logic [4:0] FN_BIPUSH  = 5'd4;
  localparam logic [4:0] FN_SWAP    = 5'd5;
  localparam logic [4:0] FN_DUP     = 5'd6;
  localparam logic [4:0] FN_OUT     = 5'd7;
  localparam logic [4:0] FN_IN      = 5'd8;
  localparam logic [4:0] FN_GOTO    = 5'd9;
  localparam logic [4:0] FN_IFEQ    = 5'd10;
  localparam logic [4:0] FN_IFLT    = 5'd11;
  localparam logic [4:0] FN_ICMPEQ  = 5'd12;
  localparam logic [4:0] FN_ILOAD   = 5'd13;
  localparam logic [4:0] FN_ISTORE  = 5'd14;
  localparam logic [4:0] FN_IINC    = 5'd15;
  localparam logic [4:0] FN_LDC     = 5'd16;
  localparam logic [4:0] FN_POOLWR  = 5'd17;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_UNDER = 2'd1;
  localparam logic [1:0] FAULT_OVER  = 2'd2;

  typedef struct packed {
    logic [4:0]         func;
    logic [15:0]        pc;
    logic [15:0]        operand;
    logic signed [7:0]  inc_const;
    logic               wide;
    logic [7:0]         in_char;
    logic signed [31:0] pool_word;
  } item_t;

  typedef struct packed {
    logic              stk_we;
    logic              stk_at_nos;  // write goes to the entry below the top
    logic              loc_we;
    logic [31:0]       loc_wdata;
    logic              pool_we;
    logic [CNT_W-1:0]  count_nxt;
    logic [31:0]       top_nxt;
    logic [15:0]       next_pc;
    logic              ovalid;
    logic [7:0]        ochar;
    logic [31:0]       top_value;
    logic [1:0]        fault;
  } exec_res_t;

  function automatic logic [31:0] sext8(input logic [7:0] v);
    logic [31:0] z;
    z = {24'b0, v};
    return ((z & SIGN_BYTE) != 32'b0) ? (EXT_BYTE | z) : z;
  endfunction

  function automatic logic [LOCALS_AW-1:0] loc_index(input logic [15:0] opnd,
                                                     input logic wide);
    logic [15:0] full;
    full = wide ? opnd : {8'b0, opnd[7:0]};
    return full[LOCALS_AW-1:0];
  endfunction

endpackage

@@ src/smx_ram.sv @@
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/smx_exec.sv @@
module smx_exec
  import smx_pkg::*;
(
  input  item_t            item,
  input  logic [CNT_W-1:0] count,
  input  logic [31:0]      top,
  input  logic [31:0]      nos,
  input  logic [31:0]      third,
  input  logic [31:0]      loc_rd,
  input  logic [31:0]      pool_rd,
  output exec_res_t        res
);

  logic [1:0]     pops;
  logic [1:0]     pushes;
  logic [2:0]     len;
  logic [CNT_W:0] cnt_after;
  logic           under;
  logic           over;
  logic           ok;
  logic [15:0]    target;
  logic [15:0]    seq_pc;
  logic [31:0]    push_val;

  always_comb begin
    pops   = 2'd0;
    pushes = 2'd0;
    len    = 3'd1;
    unique case (item.func)
      FN_ADD, FN_SUB, FN_AND, FN_OR: begin
        pops = 2'd2; pushes = 2'd1;
      end
      FN_BIPUSH: begin pushes = 2'd1; len = 3'd2; end
      FN_SWAP:   begin pops = 2'd2; pushes = 2'd2; end
      FN_DUP:    begin pops = 2'd1; pushes = 2'd2; end
      FN_OUT:    pops = 2'd1;
      FN_IN:     pushes = 2'd1;
      FN_GOTO:   len = 3'd3;
      FN_IFEQ, FN_IFLT: begin pops = 2'd1; len = 3'd3; end
      FN_ICMPEQ: begin pops = 2'd2; len = 3'd3; end
      FN_ILOAD:  begin pushes = 2'd1; len = item.wide ? 3'd3 : 3'd2; end
      FN_ISTORE: begin pops = 2'd1; len = item.wide ? 3'd3 : 3'd2; end
      FN_IINC:   len = item.wide ? 3'd4 : 3'd3;
      FN_LDC:    begin pushes = 2'd1; len = 3'd3; end
      FN_POOLWR: len = 3'd0;
      default:   len = 3'd1;
    endcase
  end

  assign cnt_after = {1'b0, count} - {{(CNT_W - 1){1'b0}}, pops}
                     + {{(CNT_W - 1){1'b0}}, pushes};
  assign under  = {1'b0, count} < {{(CNT_W - 1){1'b0}}, pops};
  assign over   = !under && (cnt_after > (CNT_W + 1)'(STACK_DEPTH));
  assign ok     = !under && !over;
  assign target = item.pc + item.operand;
  assign seq_pc = item.pc + {13'b0, len};

  always_comb begin
    case (item.func)
      FN_BIPUSH: push_val = sext8(item.operand[7:0]);
      FN_IN:     push_val = {24'b0, item.in_char};
      FN_ILOAD:  push_val = loc_rd;
      default:   push_val = pool_rd;
    endcase
  end

  always_comb begin
    res            = '0;
    res.count_nxt  = count;
    res.top_nxt    = top;
    res.next_pc    = seq_pc;
    res.loc_wdata  = top;
    res.fault      = under ? FAULT_UNDER : (over ? FAULT_OVER : FAULT_NONE);
    if (ok) begin
      res.count_nxt = cnt_after[CNT_W-1:0];
      unique case (item.func)
        FN_ADD: res.top_nxt = nos + top;
        FN_SUB: res.top_nxt = nos - top;
        FN_AND: res.top_nxt = nos & top;
        FN_OR:  res.top_nxt = nos | top;
        FN_BIPUSH, FN_IN, FN_ILOAD, FN_LDC: begin
          // The old top moves down into memory; an empty stack has none.
          res.stk_we  = (count != '0);
          res.top_nxt = push_val;
        end
        FN_SWAP: begin
          res.stk_we     = 1'b1;
          res.stk_at_nos = 1'b1;
          res.top_nxt    = nos;
        end
        FN_DUP: res.stk_we = 1'b1;
        FN_OUT: begin
          res.ovalid  = 1'b1;
          res.ochar   = top[7:0];
          res.top_nxt = nos;
        end
        FN_GOTO: res.next_pc = target;
        FN_IFEQ: begin
          res.top_nxt = nos;
          if (top == 32'b0) res.next_pc = target;
        end
        FN_IFLT: begin
          res.top_nxt = nos;
          if (top[31]) res.next_pc = target;
        end
        FN_ICMPEQ: begin
          res.top_nxt = third;
          if (nos == top) res.next_pc = target;
        end
        FN_ISTORE: begin
          res.loc_we  = 1'b1;
          res.top_nxt = nos;
        end
        FN_IINC: begin
          res.loc_we    = 1'b1;
          res.loc_wdata = loc_rd + sext8(item.inc_const);
        end
        FN_POOLWR: res.pool_we = 1'b1;
        default: res.top_nxt = top;
      endcase
    end
    res.top_value = (res.count_nxt == '0) ? 32'b0 : res.top_nxt;
  end

endmodule

@@ src/stack_machine_execute_unit.sv @@
// Channel | Handshake             | Fields
// in_     | in_valid / in_stall   | func, pc, operand, inc_const, wide, in_char, pool_word
// out_    | out_valid / out_stall | next_pc, out_valid, out_char, top_value, fault
//
// Each item passes through two steps: S_RD, in which the stack, local and pool
// memories are read, and S_EX, in which the instruction executes and writes back.
// The memory read is registered, so no new item is taken while one is in S_RD.
// Reset clears the stack count and the control state only; no stack word read
// from memory is used before it was written, so the stack memories need no clearing.
// A stalled result holds the execute cycle; a new item is taken as one retires.
module stack_machine_execute_unit
  import smx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_func,
  input  logic [15:0]        in_pc,
  input  logic [15:0]        in_operand,
  input  logic signed [7:0]  in_inc_const,
  input  logic               in_wide,
  input  logic [7:0]         in_in_char,
  input  logic signed [31:0] in_pool_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_next_pc,
  output logic               out_out_valid,
  output logic [7:0]         out_out_char,
  output logic signed [31:0] out_top_value,
  output logic [1:0]         out_fault
);

  // S_RD: memories are being read for the held item.
  // S_EX: read data is valid; the item executes when the output can take it.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EX   = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  item_t            item_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0]      top_r;

  logic             ovld_r;
  logic [15:0]      onext_pc_r;
  logic             oout_valid_r;
  logic [7:0]       oout_char_r;
  logic [31:0]      otop_r;
  logic [1:0]       ofault_r;

  logic             accept;
  logic             fire;
  exec_res_t        res;

  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic [CNT_W-1:0] cnt_m3;
  logic [STACK_AW-1:0] stk_waddr;
  logic [31:0]      stk_nos;
  logic [31:0]      stk_third;
  logic [LOCALS_AW-1:0] loc_addr;
  logic [31:0]      loc_rd;
  logic [31:0]      pool_rd;

  // The execute cycle retires when the output register is empty or drains.
  assign fire     = (state_r == S_EX) && (!ovld_r || !out_stall);
  assign in_stall = (state_r == S_RD) || ((state_r == S_EX) && !fire);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_RD;
      S_RD:   state_nxt = S_EX;
      S_EX:   if (fire) state_nxt = accept ? S_RD : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{func: in_func, pc: in_pc, operand: in_operand,
                  inc_const: in_inc_const, wide: in_wide, in_char: in_in_char,
                  pool_word: in_pool_word};
    end
  end

  // Stack layout: top_r holds entry count-1, memory holds entries below it.
  // The addresses only change at a retiring edge, so the read data stays
  // valid while the execute cycle is stalled.
  assign cnt_m1   = count_r - CNT_W'(1);
  assign cnt_m2   = count_r - CNT_W'(2);
  assign cnt_m3   = count_r - CNT_W'(3);
  assign stk_waddr = res.stk_at_nos ? cnt_m2[STACK_AW-1:0] : cnt_m1[STACK_AW-1:0];
  assign loc_addr = loc_index(item_r.operand, item_r.wide);

  // Two copies of the stack memory give two read ports; both take every write.
  smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stk_nos (
    .clk   (clk),
    .we    (fire && res.stk_we),
    .waddr (stk_waddr),
    .wdata (top_r),
    .raddr (cnt_m2[STACK_AW-1:0]),
    .rdata (stk_nos)
  );

  smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stk_third (
    .clk   (clk),
    .we    (fire && res.stk_we),
    .waddr (stk_waddr),
    .wdata (top_r),
    .raddr (cnt_m3[STACK_AW-1:0]),
    .rdata (stk_third)
  );

  smx_ram #(.WIDTH(32), .DEPTH(1 << LOCALS_AW)) u_locals (
    .clk   (clk),
    .we    (fire && res.loc_we),
    .waddr (loc_addr),
    .wdata (res.loc_wdata),
    .raddr (loc_addr),
    .rdata (loc_rd)
  );

  smx_ram #(.WIDTH(32), .DEPTH(1 << POOL_AW)) u_pool (
    .clk   (clk),
    .we    (fire && res.pool_we),
    .waddr (item_r.operand[POOL_AW-1:0]),
    .wdata (item_r.pool_word),
    .raddr (item_r.operand[POOL_AW-1:0]),
    .rdata (pool_rd)
  );

  smx_exec u_exec (
    .item    (item_r),
    .count   (count_r),
    .top     (top_r),
    .nos     (stk_nos),
    .third   (stk_third),
    .loc_rd  (loc_rd),
    .pool_rd (pool_rd),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= res.count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      top_r <= res.top_nxt;
    end
  end

  // Output register decouples the result side from the next item's read cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (fire) begin
      ovld_r <= 1'b1;
    end else if (!out_stall) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      onext_pc_r   <= res.next_pc;
      oout_valid_r <= res.ovalid;
      oout_char_r  <= res.ochar;
      otop_r       <= res.top_value;
      ofault_r     <= res.fault;
    end
  end

  assign out_valid     = ovld_r;
  assign out_next_pc   = onext_pc_r;
  assign out_out_valid = oout_valid_r;
  assign out_out_char  = oout_char_r;
  assign out_top_value = otop_r;
  assign out_fault     = ofault_r;

  // The stack never holds more entries than its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  // A faulting instruction leaves the stack count as it was.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.fault != FAULT_NONE) |=> count_r == $past(count_r))
    else $error("faulting item changed the stack count");

  // A character is only sent by an instruction that completed cleanly.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_valid |-> out_fault == FAULT_NONE)
    else $error("character output together with a fault");

  // A retiring item always shows up as a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("retired item produced no result");

endmodule
